@@ rtl/line_edit_integer_parser_unit_defines.svh @@
// Assertion macros shared by the line editing parser modules.
// The enclosing module provides clk and arst_n.
`ifndef LINE_EDIT_INTEGER_PARSER_UNIT_DEFINES_SVH
`define LINE_EDIT_INTEGER_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LEIP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LEIP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LEIP_ASSERT(lbl, prop, msg)
`define LEIP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/leip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package leip_pkg;

	localparam int LINE_DEPTH_DEF = 32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UH    = 8'h48;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LH    = 8'h68;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	typedef enum logic [2:0] {
		SEL_CHAR,
		SEL_CR,
		SEL_LF,
		SEL_BS,
		SEL_SP,
		SEL_NUM
	} out_sel_t;

	typedef struct packed {
		logic     take;
		logic     store;
		logic     erase;
		logic     rd_last;
		logic     hdr;
		logic     scan;
		logic     fin;
		logic     load;
		out_sel_t sel;
		logic     last;
	} dp_cmd_t;

	typedef struct packed {
		logic byte_zero;
		logic byte_cr;
		logic byte_bs;
		logic byte_lf;
		logic len_zero;
		logic len_full;
		logic erase_en;
		logic scan_busy;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/line_edit_integer_parser_unit.sv @@
// Line editing integer parser. Each accepted character yields zero to three results, one per
// cycle as the output register frees: a stored character is echoed (LF as CR LF), backspace
// erases with an optional BS SP BS echo, zero bytes and characters beyond the line depth are
// dropped silently. Carriage return parses the stored line by walking the line memory through
// its single read port, one character per cycle, before CR, LF and the number are delivered.
// No new character is taken while a parse or an echo is in progress, but the next character
// is taken while the final result of the previous one waits in the output register. The line
// memory needs no clearing after reset. The erase echo setting may be written at any idle time.
`timescale 1ns / 1ps
`default_nettype none
module line_edit_integer_parser_unit #(
	parameter int LINE_DEPTH = leip_pkg::LINE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic               cfg_data,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [7:0]         rx_byte,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic               out_kind,
	output      logic [7:0]         echo_byte,
	output      logic signed [31:0] value,
	output      logic               last
);
	import leip_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	leip_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	leip_dp #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_kind (out_kind),
		.echo_byte(echo_byte),
		.value    (value),
		.last     (last)
	);

endmodule
`default_nettype wire

@@ rtl/leip_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module leip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/leip_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "line_edit_integer_parser_unit_defines.svh"
module leip_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire leip_pkg::dp_sts_t sts,
	output      leip_pkg::dp_cmd_t cmd
);
	import leip_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OUT   = 3'd1;
	localparam logic [2:0] S_PLAST = 3'd2;
	localparam logic [2:0] S_PHDR  = 3'd3;
	localparam logic [2:0] S_PSCAN = 3'd4;
	localparam logic [2:0] S_PFIN  = 3'd5;

	localparam logic [1:0] M_CHAR  = 2'd0;
	localparam logic [1:0] M_LF    = 2'd1;
	localparam logic [1:0] M_ERASE = 2'd2;
	localparam logic [1:0] M_CRLF  = 2'd3;

	logic [2:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic [1:0] idx_q, idx_d;
	out_sel_t   sel;
	logic       sel_last;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		sel      = SEL_CHAR;
		sel_last = 1'b1;
		unique case (mode_q)
			M_CHAR: begin
				sel      = SEL_CHAR;
				sel_last = 1'b1;
			end
			M_LF: begin
				sel      = (idx_q == 2'd0) ? SEL_CR : SEL_CHAR;
				sel_last = (idx_q != 2'd0);
			end
			M_ERASE: begin
				sel      = (idx_q == 2'd1) ? SEL_SP : SEL_BS;
				sel_last = (idx_q == 2'd2);
			end
			M_CRLF: begin
				sel      = (idx_q == 2'd0) ? SEL_CR : ((idx_q == 2'd1) ? SEL_LF : SEL_NUM);
				sel_last = (idx_q == 2'd2);
			end
			default: begin
				sel      = SEL_CHAR;
				sel_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		idx_d       = idx_q;
		cmd         = '0;
		cmd.sel     = sel;
		cmd.last    = sel_last;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					idx_d    = 2'd0;
					priority if (sts.byte_zero) begin
						state_d = S_IDLE;
					end else if (sts.byte_cr) begin
						state_d = S_PLAST;
					end else if (sts.byte_bs) begin
						if (!sts.len_zero) begin
							cmd.erase = 1'b1;
							if (sts.erase_en) begin
								mode_d  = M_ERASE;
								state_d = S_OUT;
							end
						end
					end else if (!sts.len_full) begin
						cmd.store = 1'b1;
						mode_d    = sts.byte_lf ? M_LF : M_CHAR;
						state_d   = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sel_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			S_PLAST: begin
				cmd.rd_last = 1'b1;
				state_d     = S_PHDR;
			end
			S_PHDR: begin
				cmd.hdr = 1'b1;
				state_d = S_PSCAN;
			end
			S_PSCAN: begin
				cmd.scan = 1'b1;
				if (!sts.scan_busy) begin
					state_d = S_PFIN;
				end
			end
			S_PFIN: begin
				cmd.fin = 1'b1;
				mode_d  = M_CRLF;
				idx_d   = 2'd0;
				state_d = S_OUT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= M_CHAR;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			idx_q   <= idx_d;
		end
	end

	`LEIP_ASSERT(a_cmd_exclusive, $onehot0({cmd.store, cmd.erase, cmd.hdr, cmd.scan, cmd.fin, cmd.load}), "datapath commands overlap")
	`LEIP_ASSERT(a_fin_then_out, cmd.fin |=> (state_q == S_OUT) && (idx_q == 2'd0), "parse end did not start the output sequence")

endmodule
`default_nettype wire

@@ rtl/leip_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "line_edit_integer_parser_unit_defines.svh"
module leip_dp #(
	parameter int LINE_DEPTH = leip_pkg::LINE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_data,
	input  wire logic               out_ready,
	input  wire leip_pkg::dp_cmd_t  cmd,
	output      leip_pkg::dp_sts_t  sts,
	output      logic               out_valid,
	output      logic               out_kind,
	output      logic [7:0]         echo_byte,
	output      logic signed [31:0] value,
	output      logic               last
);
	import leip_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int LW = $clog2(LINE_DEPTH + 1);

	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_DIG  = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;

	logic [LW-1:0] len_q;
	logic [7:0]    c_q;
	logic [7:0]    b_q [3];
	logic          erase_en_q;
	logic [LW-1:0] rd_ptr_q;
	logic [LW-1:0] end_q;
	logic          d_vld_q;
	logic          neg_q, hex_q, empty_q, dneg_q;
	logic [1:0]    phase_q;
	logic [31:0]   acc_q;
	logic [31:0]   num_q;

	logic          out_valid_q;
	logic          out_kind_q;
	logic [7:0]    echo_byte_q;
	logic [31:0]   value_q;
	logic          last_q;

	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    rdata;
	logic          issue;

	logic          h_neg, h_prefix, h_sfx, h_empty;
	logic [7:0]    h_bp0, h_bp1;
	logic [LW-1:0] h_p1, h_pos, h_end;

	logic          c_digit, c_space, c_upper, c_lower;
	logic [31:0]   hex_dig, acc_hex, acc_dec;

	assign issue     = cmd.scan && (rd_ptr_q < end_q);
	assign ram_re    = cmd.rd_last || issue;
	assign ram_raddr = cmd.rd_last ? AW'(len_q - LW'(1)) : rd_ptr_q[AW-1:0];

	leip_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(len_q[AW-1:0]),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_comb begin
		h_neg    = (len_q != '0) && (b_q[0] == CH_MINUS);
		h_bp0    = h_neg ? b_q[1] : b_q[0];
		h_bp1    = h_neg ? b_q[2] : b_q[1];
		h_p1     = h_neg ? LW'(2) : LW'(1);
		h_prefix = (h_p1 < len_q) && (h_bp0 == CH_ZERO) &&
			((h_bp1 == CH_LX) || (h_bp1 == CH_UX));
		h_pos    = LW'(h_neg) + (h_prefix ? LW'(2) : LW'(0));
		h_empty  = (h_pos >= len_q);
		h_sfx    = (rdata == CH_LH) || (rdata == CH_UH);
		h_end    = h_empty ? h_pos : (len_q - LW'(h_sfx));
	end

	always_comb begin
		c_digit = (rdata >= CH_ZERO) && (rdata <= CH_NINE);
		c_space = (rdata == CH_SP) || ((rdata >= CH_TAB) && (rdata <= CH_CR));
		c_upper = (rdata >= CH_UA) && (rdata <= CH_UZ);
		c_lower = (rdata >= CH_LA) && (rdata <= CH_LZ);
		priority if (c_upper) begin
			hex_dig = {24'd0, rdata} - {24'd0, CH_UA} + 32'd10;
		end else if (c_lower) begin
			hex_dig = {24'd0, rdata} - {24'd0, CH_LA} + 32'd10;
		end else begin
			hex_dig = {24'd0, rdata} - {24'd0, CH_ZERO};
		end
		acc_hex = {acc_q[27:0], 4'd0} + hex_dig;
		acc_dec = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} + {28'd0, rdata[3:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			erase_en_q <= 1'b1;
			d_vld_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				erase_en_q <= cfg_data;
			end
			d_vld_q <= issue;
			priority if (cmd.store) begin
				len_q <= len_q + LW'(1);
			end else if (cmd.erase) begin
				len_q <= len_q - LW'(1);
			end else if (cmd.fin) begin
				len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			c_q <= rx_byte;
		end
		if (cmd.store && (len_q < LW'(3))) begin
			b_q[len_q[1:0]] <= rx_byte;
		end
		if (cmd.hdr) begin
			neg_q    <= h_neg;
			hex_q    <= h_prefix || h_sfx;
			empty_q  <= h_empty;
			rd_ptr_q <= h_pos;
			end_q    <= h_end;
			dneg_q   <= 1'b0;
			phase_q  <= PH_SKIP;
			acc_q    <= '0;
		end else begin
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + LW'(1);
			end
			if (d_vld_q) begin
				if (hex_q) begin
					acc_q <= acc_hex;
				end else begin
					unique case (phase_q)
						PH_SKIP: begin
							priority if (c_space) begin
								phase_q <= PH_SKIP;
							end else if (rdata == CH_PLUS) begin
								phase_q <= PH_DIG;
							end else if (rdata == CH_MINUS) begin
								phase_q <= PH_DIG;
								dneg_q  <= 1'b1;
							end else if (c_digit) begin
								phase_q <= PH_DIG;
								acc_q   <= acc_dec;
							end else begin
								phase_q <= PH_STOP;
							end
						end
						PH_DIG: begin
							if (c_digit) begin
								acc_q <= acc_dec;
							end else begin
								phase_q <= PH_STOP;
							end
						end
						default: begin
							phase_q <= PH_STOP;
						end
					endcase
				end
			end
		end
		if (cmd.fin) begin
			if (empty_q) begin
				num_q <= '1;
			end else begin
				num_q <= (neg_q ^ dneg_q) ? (32'd0 - acc_q) : acc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q     <= cmd.last;
			out_kind_q <= 1'b0;
			value_q    <= '0;
			unique case (cmd.sel)
				SEL_CHAR: echo_byte_q <= c_q;
				SEL_CR:   echo_byte_q <= CH_CR;
				SEL_LF:   echo_byte_q <= CH_LF;
				SEL_BS:   echo_byte_q <= CH_BS;
				SEL_SP:   echo_byte_q <= CH_SP;
				SEL_NUM: begin
					echo_byte_q <= CH_NUL;
					out_kind_q  <= 1'b1;
					value_q     <= num_q;
				end
				default:  echo_byte_q <= CH_NUL;
			endcase
		end
	end

	always_comb begin
		sts.byte_zero = (rx_byte == CH_NUL);
		sts.byte_cr   = (rx_byte == CH_CR);
		sts.byte_bs   = (rx_byte == CH_BS);
		sts.byte_lf   = (rx_byte == CH_LF);
		sts.len_zero  = (len_q == '0);
		sts.len_full  = (len_q >= LW'(LINE_DEPTH));
		sts.erase_en  = erase_en_q;
		sts.scan_busy = (rd_ptr_q < end_q) || d_vld_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign echo_byte = echo_byte_q;
	assign value     = signed'(value_q);
	assign last      = last_q;

	`LEIP_ASSERT(a_len_bound, len_q <= LW'(LINE_DEPTH), "line length passed the buffer depth")
	`LEIP_ASSERT(a_store_room, cmd.store |-> (len_q < LW'(LINE_DEPTH)), "store into a full line")
	`LEIP_ASSERT(a_scan_ptr, cmd.scan |-> (rd_ptr_q <= end_q) && (end_q <= len_q), "bad scan range")
	`LEIP_ASSERT(a_load_free, cmd.load |-> (!out_valid_q || out_ready), "result overwritten")

endmodule
`default_nettype wire

@@ tb/line_edit_integer_parser_unit_test.sv @@
`timescale 1ns / 1ps
module line_edit_integer_parser_unit_test;
	import leip_pkg::*;

	localparam int LINE_DEPTH = LINE_DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_HOLD = 40;
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_NUMBER = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  ch;
		logic [31:0] num;
		logic        fin;
	} tx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic out_kind;
	logic [7:0] echo_byte;
	logic signed [31:0] value;
	logic last;

	logic [7:0] line_buf [LINE_DEPTH];
	int unsigned line_len = 0;
	bit erase_echo = 1'b1;
	tx_item_t pending_tx [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_items = 0;
	int echoes_seen = 0;
	int numbers_seen = 0;
	int err_count = 0;
	int quiet_cycles = 0;

	line_edit_integer_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind (out_kind),
		.echo_byte(echo_byte),
		.value    (value),
		.last     (last)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void queue_tx(input logic kind, input logic [7:0] ch,
			input logic [31:0] num, input logic fin);
		tx_item_t t;
		t.kind = kind;
		t.ch = ch;
		t.num = num;
		t.fin = fin;
		pending_tx.push_back(t);
	endfunction

	function automatic logic [31:0] line_number();
		int unsigned pos;
		int unsigned stop;
		bit neg;
		bit hex;
		bit dneg;
		logic [31:0] acc;
		logic [7:0] c;
		pos = 0;
		stop = line_len;
		neg = 1'b0;
		hex = 1'b0;
		dneg = 1'b0;
		acc = '0;
		if (pos < stop && line_buf[pos] == CH_MINUS) begin
			neg = 1'b1;
			pos++;
		end
		if (pos + 1 < stop && line_buf[pos] == CH_ZERO &&
				(line_buf[pos + 1] == CH_LX || line_buf[pos + 1] == CH_UX)) begin
			hex = 1'b1;
			pos += 2;
		end
		if (pos >= stop)
			return '1;
		if (line_buf[stop - 1] == CH_LH || line_buf[stop - 1] == CH_UH) begin
			hex = 1'b1;
			stop--;
		end
		if (hex) begin
			for (; pos < stop; pos++) begin
				c = line_buf[pos];
				if (c >= CH_UA && c <= CH_UZ)
					acc = (acc << 4) + c - CH_UA + 32'd10;
				else if (c >= CH_LA && c <= CH_LZ)
					acc = (acc << 4) + c - CH_LA + 32'd10;
				else
					acc = (acc << 4) + c - CH_ZERO;
			end
		end else begin
			while (pos < stop && (line_buf[pos] == CH_SP ||
					(line_buf[pos] >= CH_TAB && line_buf[pos] <= CH_CR)))
				pos++;
			if (pos < stop && (line_buf[pos] == CH_PLUS || line_buf[pos] == CH_MINUS)) begin
				dneg = (line_buf[pos] == CH_MINUS);
				pos++;
			end
			while (pos < stop && line_buf[pos] >= CH_ZERO && line_buf[pos] <= CH_NINE) begin
				acc = acc * 32'd10 + (line_buf[pos] - CH_ZERO);
				pos++;
			end
			if (dneg)
				acc = 32'd0 - acc;
		end
		if (neg)
			acc = 32'd0 - acc;
		return acc;
	endfunction

	function automatic void predict_rx(input logic [7:0] c);
		if (c == CH_NUL)
			return;
		if (c == CH_CR) begin
			queue_tx(KIND_ECHO, CH_CR, '0, 1'b0);
			queue_tx(KIND_ECHO, CH_LF, '0, 1'b0);
			queue_tx(KIND_NUMBER, CH_NUL, line_number(), 1'b1);
			line_len = 0;
		end else if (c == CH_BS) begin
			if (line_len > 0) begin
				line_len--;
				if (erase_echo) begin
					queue_tx(KIND_ECHO, CH_BS, '0, 1'b0);
					queue_tx(KIND_ECHO, CH_SP, '0, 1'b0);
					queue_tx(KIND_ECHO, CH_BS, '0, 1'b1);
				end
			end
		end else if (line_len < LINE_DEPTH) begin
			line_buf[line_len] = c;
			line_len++;
			if (c == CH_LF)
				queue_tx(KIND_ECHO, CH_CR, '0, 1'b0);
			queue_tx(KIND_ECHO, c, '0, 1'b1);
		end
	endfunction

	task automatic send_rx_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		rx_byte <= c;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_rx(c);
		if (c != CH_NUL)
			rx_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_rx_char(s[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_tx.size() != 0);
	endtask

	task automatic write_erase_echo(input bit en);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_data <= en;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		erase_echo = en;
	endtask

	function automatic logic [7:0] pick_hex_char();
		string digits;
		digits = "0123456789abcdefABCDEFgzGZ";
		return digits[$urandom_range(digits.len() - 1)];
	endfunction

	task automatic send_random_line();
		logic [7:0] text [$];
		int shape;
		int n;
		shape = $urandom_range(9);
		if ($urandom_range(3) == 0)
			text.push_back(CH_MINUS);
		case (shape)
			0, 1, 2: begin
				repeat ($urandom_range(2))
					text.push_back($urandom_range(1) ? CH_SP : CH_TAB);
				if ($urandom_range(1))
					text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
				n = $urandom_range(1, 12);
				repeat (n) text.push_back(8'(CH_ZERO + $urandom_range(9)));
				if ($urandom_range(3) == 0)
					text.push_back(8'($urandom_range(1, 255)));
			end
			3, 4: begin
				text.push_back(CH_ZERO);
				text.push_back($urandom_range(1) ? CH_LX : CH_UX);
				n = $urandom_range(0, 9);
				repeat (n) text.push_back(pick_hex_char());
			end
			5, 6: begin
				n = $urandom_range(1, 9);
				repeat (n) text.push_back(pick_hex_char());
				text.push_back($urandom_range(1) ? CH_LH : CH_UH);
			end
			7: begin
				n = $urandom_range(28, 40);
				repeat (n) text.push_back($urandom_range(1) ?
					8'(CH_ZERO + $urandom_range(9)) : 8'($urandom_range(33, 126)));
			end
			8: begin
				n = $urandom_range(0, 6);
				repeat (n) text.push_back(8'($urandom_range(1, 255)));
			end
			default: ;
		endcase
		foreach (text[i]) begin
			if ($urandom_range(7) == 0) begin
				send_rx_char(8'($urandom_range(32, 126)));
				send_rx_char(CH_BS);
			end
			send_rx_char(text[i]);
		end
		send_rx_char(CH_CR);
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_rx_char(8'($urandom_range(255)));
	endtask

	task automatic test_empty_lines();
		send_rx_char(CH_CR);
		send_rx_char(CH_MINUS);
		send_rx_char(CH_CR);
	endtask

	task automatic test_byte_extremes();
		send_rx_char(CH_NUL);
		send_rx_char(8'hFF);
		send_rx_char(CH_CR);
	endtask

	task automatic test_hex_forms();
		send_text("-0xFF");
		send_rx_char(CH_CR);
		send_text("1Ah");
		send_rx_char(CH_CR);
	endtask

	task automatic test_decimal_with_lf();
		send_rx_char(CH_LF);
		send_text("+9");
		send_rx_char(CH_CR);
	endtask

	task automatic test_erase();
		send_text("52");
		send_rx_char(CH_BS);
		send_rx_char(CH_CR);
		write_erase_echo(1'b0);
		send_text("7");
		send_rx_char(CH_BS);
		send_rx_char(CH_BS);
		send_rx_char(CH_CR);
		write_erase_echo(1'b1);
	endtask

	task automatic test_random_lines(input int send_pct, input int recv_pct, input int items);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = rx_items + items;
		while (rx_items < target) begin
			if ($urandom_range(14) == 0)
				wait_drained();
			if ($urandom_range(4) == 0)
				send_noise($urandom_range(1, 4));
			else
				send_random_line();
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		tx_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (out_kind === KIND_NUMBER)
				numbers_seen++;
			else
				echoes_seen++;
			if (pending_tx.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0b byte %02h value %0d",
					out_kind, echo_byte, value));
			end else begin
				want = pending_tx.pop_front();
				if (out_kind !== want.kind)
					report_mismatch($sformatf("out_kind %0b, wanted %0b", out_kind, want.kind));
				if (echo_byte !== want.ch)
					report_mismatch($sformatf("echo_byte %02h, wanted %02h", echo_byte, want.ch));
				if (value !== want.num)
					report_mismatch($sformatf("value %0d, wanted %0d", value,
						$signed(want.num)));
				if (last !== want.fin)
					report_mismatch($sformatf("last %0b, wanted %0b", last, want.fin));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("line_edit_integer_parser_unit_test: errors");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		recv_idle_pct = 0;
		test_empty_lines();
		test_byte_extremes();
		test_hex_forms();
		test_decimal_with_lf();
		test_erase();
		test_random_lines(15, 52, 72);
		write_erase_echo(1'b0);
		test_random_lines(52, 15, 72);
		write_erase_echo(1'b1);
		test_random_lines(0, 0, 72);
		wait_drained();
		repeat (DRAIN_HOLD) @(posedge clk);
		$display("Sent %0d characters; checked %0d echoes and %0d parsed numbers.",
			rx_items, echoes_seen, numbers_seen);
		$display("Covered erase echo on and off, full lines and three pacing modes.");
		if (err_count == 0)
			$display("line_edit_integer_parser_unit_test: clean");
		else
			$display("line_edit_integer_parser_unit_test: errors");
		$finish;
	end

endmodule
